[src/swhc_pkg.sv]
// Shared types and constants for the sliding-window keyed hit counter.
package swhc_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned KEY_BITS   = 8;
  localparam int unsigned TIME_BITS  = 32;

  localparam int unsigned KEY_COUNT  = 1 << KEY_BITS;
  localparam int unsigned PTR_BITS   = $clog2(RING_DEPTH);
  localparam int unsigned OCC_BITS   = $clog2(RING_DEPTH + 1);
  localparam int unsigned WIN_BITS   = 32;
  localparam int unsigned CMP_BITS   = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;
  localparam int unsigned CNT_OUT_BITS = 9;
  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned ENTRY_BITS = TIME_BITS + KEY_BITS;

  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 2;

  // Register map
  localparam logic [APB_ADDR_BITS-1:0] REG_WINDOW_ADDR = '0;
  localparam logic [WIN_BITS-1:0]      WINDOW_RESET    = WIN_BITS'(300);

  // Item modes
  localparam logic [MODE_BITS-1:0] MODE_HIT   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_KEY   = 2'd1;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] timestamp;
  } swhc_in_t;

  typedef struct packed {
    logic [CNT_OUT_BITS-1:0] count;
    logic                    dropped;
  } swhc_out_t;

  // Counter table access from the controller
  typedef struct packed {
    logic                rd_en;
    logic [KEY_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [KEY_BITS-1:0] wr_addr;
    logic [OCC_BITS-1:0] wr_data;
  } swhc_cnt_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXP_CHK,
    ST_EXP_CNT,
    ST_MAIN
  } swhc_state_e;

  // Step a ring pointer with wrap
  function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] r;
    if (p == PTR_BITS'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_BITS'(1);
    end
    return r;
  endfunction

endpackage

[src/swhc_key_table.sv]
// Per-key hit counter memory with per-entry valid bits for reset clearing.
module swhc_key_table import swhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swhc_cnt_req_t       req_i,
  output logic [OCC_BITS-1:0] rd_cnt_o
);

  logic [OCC_BITS-1:0]  mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] vld_q;
  logic [OCC_BITS-1:0]  rd_data_q;
  logic                 rd_vld_q;

  // Write and read the counter array; read data is registered
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      if (req_i.wr_en && (req_i.wr_addr == req_i.rd_addr)) begin
        rd_data_q <= req_i.wr_data;
      end else begin
        rd_data_q <= mem[req_i.rd_addr];
      end
    end
  end

  // Track written entries; an unwritten counter reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr] ||
                    (req_i.wr_en && (req_i.wr_addr == req_i.rd_addr));
      end
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_cnt_o = rd_vld_q ? rd_data_q : '0;

endmodule

[src/sliding_window_keyed_hit_counter.sv]
// Flow: each accepted item passes ST_EXP_CHK and ST_MAIN, which loads the result beat;
//   each expired hit adds an ST_EXP_CNT / ST_EXP_CHK pass, and an output stall holds ST_MAIN.
//   One item at a time, paced by the ring-read / counter-read trip through two registered memories.
// Reset: key counters read as zero at once (valid bits), ring empty, window 300.
// Ring contents are not cleared; only written entries are read.
module sliding_window_keyed_hit_counter import swhc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  swhc_in_t                 in_data_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output swhc_out_t                out_data_o,
  // configuration
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [APB_ADDR_BITS-1:0] paddr_i,
  input  logic [APB_DATA_BITS-1:0] pwdata_i,
  output logic [APB_DATA_BITS-1:0] prdata_o,
  output logic                     pready_o
);

  swhc_state_e state_q, state_d;

  logic [WIN_BITS-1:0]  window_q;
  logic [PTR_BITS-1:0]  head_q, head_d;
  logic [PTR_BITS-1:0]  tail_q, tail_d;
  logic [OCC_BITS-1:0]  occ_q, occ_d;

  // Item held while it is worked on
  logic [MODE_BITS-1:0] mode_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [TIME_BITS-1:0] time_q;
  logic [TIME_BITS-1:0] limit_q;
  logic                 exp_en_q;
  logic [KEY_BITS-1:0]  pop_key_q, pop_key_d;

  logic                 out_valid_q;
  swhc_out_t            out_q, out_d;

  logic                 in_acc;
  logic                 fire_main;
  logic                 load_out;

  // Ring memory
  logic [ENTRY_BITS-1:0] ring_mem [RING_DEPTH];
  logic [ENTRY_BITS-1:0] ring_rd_q;
  logic                  ring_re;
  logic [PTR_BITS-1:0]   ring_raddr;
  logic                  ring_we;
  logic [ENTRY_BITS-1:0] ring_wdata;
  logic [TIME_BITS-1:0]  head_time;
  logic [KEY_BITS-1:0]   head_key;

  swhc_cnt_req_t         cnt_req;
  logic [OCC_BITS-1:0]   cnt_rd;

  logic                  pop;
  logic                  cfg_wr;
  logic [CMP_BITS-1:0]   now_ext;
  logic [CMP_BITS-1:0]   win_ext;

  assign head_time = ring_rd_q[ENTRY_BITS-1:KEY_BITS];
  assign head_key  = ring_rd_q[KEY_BITS-1:0];

  // Configuration register
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i == REG_WINDOW_ADDR);
  assign prdata_o = (paddr_i == REG_WINDOW_ADDR) ? APB_DATA_BITS'(window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_q <= WIN_BITS'(pwdata_i);
    end
  end

  // Handshake
  assign fire_main  = (state_q == ST_MAIN) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == ST_IDLE) || fire_main);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign now_ext = CMP_BITS'(in_data_i.timestamp);
  assign win_ext = CMP_BITS'(window_q);
  assign pop     = (occ_q != '0) && exp_en_q && (head_time <= limit_q);

  // Next state, memory requests and result
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    pop_key_d  = pop_key_q;
    out_d      = out_q;
    load_out   = 1'b0;
    ring_re    = 1'b0;
    ring_raddr = head_q;
    ring_we    = 1'b0;
    ring_wdata = {time_q, key_q};
    cnt_req    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ring_re = 1'b1;
          state_d = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        // Decide whether the head hit has left the window
        cnt_req.rd_en = 1'b1;
        if (pop) begin
          cnt_req.rd_addr = head_key;
          pop_key_d       = head_key;
          state_d         = ST_EXP_CNT;
        end else begin
          cnt_req.rd_addr = key_q;
          state_d         = ST_MAIN;
        end
      end
      ST_EXP_CNT: begin
        // Drop the head hit and fetch the next head
        if (cnt_rd != '0) begin
          cnt_req.wr_en   = 1'b1;
          cnt_req.wr_addr = pop_key_q;
          cnt_req.wr_data = cnt_rd - OCC_BITS'(1);
        end
        head_d     = ptr_next(head_q);
        occ_d      = occ_q - OCC_BITS'(1);
        ring_re    = 1'b1;
        ring_raddr = ptr_next(head_q);
        state_d    = ST_EXP_CHK;
      end
      ST_MAIN: begin
        if (fire_main) begin
          load_out      = 1'b1;
          out_d.dropped = 1'b0;
          case (mode_q)
            MODE_HIT: begin
              if (occ_q == OCC_BITS'(RING_DEPTH)) begin
                out_d.dropped = 1'b1;
                out_d.count   = CNT_OUT_BITS'(cnt_rd);
              end else begin
                ring_we         = 1'b1;
                tail_d          = ptr_next(tail_q);
                occ_d           = occ_q + OCC_BITS'(1);
                cnt_req.wr_en   = 1'b1;
                cnt_req.wr_addr = key_q;
                cnt_req.wr_data = cnt_rd + OCC_BITS'(1);
                out_d.count     = CNT_OUT_BITS'(cnt_rd + OCC_BITS'(1));
              end
            end
            MODE_KEY: out_d.count = CNT_OUT_BITS'(cnt_rd);
            default:  out_d.count = CNT_OUT_BITS'(occ_q);
          endcase
          // Take the next item right away; head is unchanged here
          if (in_acc) begin
            ring_re = 1'b1;
            state_d = ST_EXP_CHK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Ring memory with bypass of a same-entry write
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[tail_q] <= ring_wdata;
    end
    if (ring_re) begin
      if (ring_we && (tail_q == ring_raddr)) begin
        ring_rd_q <= ring_wdata;
      end else begin
        ring_rd_q <= ring_mem[ring_raddr];
      end
    end
  end

  swhc_key_table u_key_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (cnt_req),
    .rd_cnt_o (cnt_rd)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold item, expiry limit and result beat
  always_ff @(posedge clk_i) begin
    pop_key_q <= pop_key_d;
    if (in_acc) begin
      mode_q   <= in_data_i.mode;
      key_q    <= in_data_i.key;
      time_q   <= in_data_i.timestamp;
      exp_en_q <= (now_ext >= win_ext);
      limit_q  <= TIME_BITS'(now_ext - win_ext);
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

endmodule
